// ===== hdl/sll_pkg.sv =====
// ============================================================================
// Static linked list package
// Transaction payload types and result status codes shared by the list engine.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package sll_pkg;

    localparam logic       MODE_INSERT = 1'b0;
    localparam logic       MODE_DELETE = 1'b1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic               mode;
        logic [7:0]         position;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic [1:0]         status;
        logic [7:0]         count;
        logic signed [31:0] removed_value;
    } t_out;

endpackage

`default_nettype wire

// ===== hdl/static_linked_list_engine_core.sv =====
// ============================================================================
// Static linked list engine
// Cursor-linked list with a free list, held in a link RAM and a value RAM.
// ============================================================================
// Usage:
//   The input channel carries one operation per transaction: an insert of a
//   value at a one-based position, or a delete of the element at a position.
//   Every operation returns exactly one result transaction with a status, the
//   element count after the operation and, for a delete, the removed value.
//   One operation is worked on at a time. The link RAM is read once per
//   cycle while walking the list, and the next operation can be accepted
//   in the cycle after the result is loaded. After reset the link RAM is
//   initialised by a sweep over all SLOTS entries, during which o_in_stall
//   stays high. The value RAM is not initialised.
//   The result is held in an output register; the next operation is accepted
//   while it waits, but a further result waits until the receiver drops
//   i_out_stall.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module static_linked_list_engine_core #(
    parameter int SLOTS = 256
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire sll_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output sll_pkg::t_out      o_out_data
);

    localparam int LW   = $clog2(SLOTS);
    localparam int CW   = $clog2(SLOTS);
    localparam int CMPW = ((CW > 8) ? CW : 8) + 1;

    localparam logic [LW-1:0] FREE_HEAD = '0;
    localparam logic [LW-1:0] DATA_HEAD = LW'(SLOTS - 1);
    localparam logic [LW-1:0] LAST_LINK = LW'(SLOTS - 2);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_I_SLOT = 4'd2;
    localparam logic [3:0] S_I_NF   = 4'd3;
    localparam logic [3:0] S_WALK   = 4'd4;
    localparam logic [3:0] S_I_W1   = 4'd5;
    localparam logic [3:0] S_I_W2   = 4'd6;
    localparam logic [3:0] S_D_VN   = 4'd7;
    localparam logic [3:0] S_D_FH   = 4'd8;
    localparam logic [3:0] S_D_FREE = 4'd9;
    localparam logic [3:0] S_RESP   = 4'd10;

    function automatic logic [7:0] f_cnt8(input logic [CW-1:0] c);
        logic [CMPW-1:0] e;
        e = CMPW'(c);
        return e[7:0];
    endfunction

    // Control registers
    logic [3:0]    r_state, n_state;
    logic [LW-1:0] r_clr, n_clr;
    logic [CW-1:0] r_count, n_count;
    logic          r_out_valid, n_out_valid;

    // Payload registers
    sll_pkg::t_out      r_out_data, n_out_data;
    sll_pkg::t_out      r_res, n_res;
    logic               r_mode, n_mode;
    logic signed [31:0] r_value, n_value;
    logic [7:0]         r_left, n_left;
    logic [LW-1:0]      r_cur, n_cur;
    logic [LW-1:0]      r_pred, n_pred;
    logic [LW-1:0]      r_slot, n_slot;
    logic [LW-1:0]      r_nxt, n_nxt;

    // Memory ports
    logic          w_link_we;
    logic [LW-1:0] w_link_waddr;
    logic [LW-1:0] w_link_wdata;
    logic [LW-1:0] w_link_raddr;
    logic [LW-1:0] w_link_rdata;
    logic          w_val_we;
    logic [31:0]   w_val_rdata;

    logic            w_accept;
    logic            w_load;
    logic            w_ins_bad;
    logic            w_del_bad;
    logic [CMPW-1:0] w_pos_ext;
    logic [CMPW-1:0] w_cnt_ext;

    sll_ram #(
        .WIDTH (LW),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_link_we),
        .i_waddr (w_link_waddr),
        .i_wdata (w_link_wdata),
        .i_raddr (w_link_raddr),
        .o_rdata (w_link_rdata)
    );

    // The value read address follows the link read data: at the end of a
    // delete walk that data is the slot being removed.
    sll_ram #(
        .WIDTH (32),
        .DEPTH (SLOTS)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (w_val_we),
        .i_waddr (r_slot),
        .i_wdata (r_value),
        .i_raddr (w_link_rdata),
        .o_rdata (w_val_rdata)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign w_accept  = i_in_valid && (r_state == S_IDLE);
    assign w_load    = (r_state == S_RESP) && (!r_out_valid || !i_out_stall);
    assign w_pos_ext = CMPW'(i_in_data.position);
    assign w_cnt_ext = CMPW'(r_count);
    assign w_ins_bad = (i_in_data.position == 8'd0) || (w_pos_ext > w_cnt_ext + CMPW'(1));
    assign w_del_bad = (i_in_data.position == 8'd0) || (w_pos_ext > w_cnt_ext);

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_count      = r_count;
        n_res        = r_res;
        n_mode       = r_mode;
        n_value      = r_value;
        n_left       = r_left;
        n_cur        = r_cur;
        n_pred       = r_pred;
        n_slot       = r_slot;
        n_nxt        = r_nxt;
        w_link_we    = 1'b0;
        w_link_waddr = '0;
        w_link_wdata = '0;
        w_link_raddr = r_cur;
        w_val_we     = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                w_link_we    = 1'b1;
                w_link_waddr = r_clr;
                w_link_wdata = (r_clr < LAST_LINK) ? r_clr + LW'(1) : '0;
                if (r_clr == DATA_HEAD) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + LW'(1);
                end
            end
            S_IDLE: begin
                w_link_raddr = (i_in_data.mode == sll_pkg::MODE_DELETE) ? DATA_HEAD
                                                                       : FREE_HEAD;
                if (w_accept) begin
                    n_mode  = i_in_data.mode;
                    n_value = i_in_data.value;
                    n_left  = i_in_data.position - 8'd1;
                    n_cur   = DATA_HEAD;
                    n_res.count         = f_cnt8(r_count);
                    n_res.removed_value = '0;
                    if (i_in_data.mode == sll_pkg::MODE_DELETE) begin
                        if (w_del_bad) begin
                            n_res.status = sll_pkg::ST_RANGE;
                            n_state      = S_RESP;
                        end else begin
                            n_state = S_WALK;
                        end
                    end else begin
                        if (w_ins_bad) begin
                            n_res.status = sll_pkg::ST_RANGE;
                            n_state      = S_RESP;
                        end else begin
                            n_state = S_I_SLOT;
                        end
                    end
                end
            end
            S_I_SLOT: begin
                if (w_link_rdata == FREE_HEAD || w_link_rdata == DATA_HEAD) begin
                    n_res.status = sll_pkg::ST_FULL;
                    n_state      = S_RESP;
                end else begin
                    n_slot       = w_link_rdata;
                    w_link_raddr = w_link_rdata;
                    n_state      = S_I_NF;
                end
            end
            S_I_NF: begin
                // Pop the slot off the free list and start the walk.
                w_link_we    = 1'b1;
                w_link_waddr = FREE_HEAD;
                w_link_wdata = w_link_rdata;
                w_link_raddr = DATA_HEAD;
                n_state      = S_WALK;
            end
            S_WALK: begin
                // The read of r_cur's link was issued in the previous cycle.
                if (r_left == 8'd0) begin
                    n_pred = r_cur;
                    if (r_mode == sll_pkg::MODE_INSERT) begin
                        n_nxt   = w_link_rdata;
                        n_state = S_I_W1;
                    end else begin
                        n_slot = w_link_rdata;
                        if (w_link_rdata == FREE_HEAD || w_link_rdata == DATA_HEAD) begin
                            n_res.status = sll_pkg::ST_RANGE;
                            n_state      = S_RESP;
                        end else begin
                            w_link_raddr = w_link_rdata;
                            n_state      = S_D_VN;
                        end
                    end
                end else begin
                    w_link_raddr = w_link_rdata;
                    n_cur        = w_link_rdata;
                    n_left       = r_left - 8'd1;
                end
            end
            S_I_W1: begin
                w_link_we    = 1'b1;
                w_link_waddr = r_slot;
                w_link_wdata = r_nxt;
                w_val_we     = 1'b1;
                n_state      = S_I_W2;
            end
            S_I_W2: begin
                w_link_we           = 1'b1;
                w_link_waddr        = r_pred;
                w_link_wdata        = r_slot;
                n_count             = r_count + CW'(1);
                n_res.status        = sll_pkg::ST_DONE;
                n_res.count         = f_cnt8(r_count + CW'(1));
                n_res.removed_value = '0;
                n_state             = S_RESP;
            end
            S_D_VN: begin
                // Unlink the element and fetch the free list head.
                w_link_we           = 1'b1;
                w_link_waddr        = r_pred;
                w_link_wdata        = w_link_rdata;
                n_res.removed_value = w_val_rdata;
                w_link_raddr        = FREE_HEAD;
                n_state             = S_D_FH;
            end
            S_D_FH: begin
                w_link_we    = 1'b1;
                w_link_waddr = r_slot;
                w_link_wdata = w_link_rdata;
                n_state      = S_D_FREE;
            end
            S_D_FREE: begin
                w_link_we    = 1'b1;
                w_link_waddr = FREE_HEAD;
                w_link_wdata = r_slot;
                n_count      = r_count - CW'(1);
                n_res.status = sll_pkg::ST_DONE;
                n_res.count  = f_cnt8(r_count - CW'(1));
                n_state      = S_RESP;
            end
            S_RESP: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_data  = r_res;
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_res      <= n_res;
        r_mode     <= n_mode;
        r_value    <= n_value;
        r_left     <= n_left;
        r_cur      <= n_cur;
        r_pred     <= n_pred;
        r_slot     <= n_slot;
        r_nxt      <= n_nxt;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMPW'(r_count) <= CMPW'(SLOTS - 2))
        else $error("element count exceeds the slot capacity");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_RESP) |-> !w_link_we && !w_val_we)
        else $error("memory written while no operation is in progress");

    a_walk_not_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_cur != FREE_HEAD))
        else $error("list walk reached the free list head");

    a_load_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_state == S_IDLE) && r_out_valid)
        else $error("result loaded without returning to idle");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |=> (r_count == $past(r_count)))
        else $error("element count changed on acceptance");

endmodule

`default_nettype wire

// ===== hdl/sll_ram.sv =====
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module sll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== tb/static_linked_list_engine_core_tb.sv =====
// ============================================================================
// Static linked list engine testbench
// Drives insert and delete transactions into the list engine under varying
// idle and stall patterns. A cycle-free model of the slot array and free list
// predicts each result, and the monitor compares every result field by field.
// ============================================================================
`timescale 1ns / 1ps

module static_linked_list_engine_core_tb;

    localparam int LIST_SLOTS   = 256;
    localparam int FREE_HEAD    = 0;
    localparam int DATA_HEAD    = LIST_SLOTS - 1;
    localparam int MAX_ELEMENTS = LIST_SLOTS - 2;
    localparam int TAIL_CYCLES  = LIST_SLOTS + 40;
    localparam int HOLD_CYCLES  = 400;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    sll_pkg::t_in  in_data = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    sll_pkg::t_out out_data;

    // Operations waiting to be offered and results waiting to arrive.
    sll_pkg::t_in  pending_ops[$];
    sll_pkg::t_out expected_results[$];

    // Shadow of the list: links, values and element count.
    logic [7:0]         list_link[LIST_SLOTS];
    logic signed [31:0] list_value[LIST_SLOTS];
    int                 list_count;

    // Element count as seen by the stimulus generator once all queued
    // operations have been applied.
    int gen_count = 0;

    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic long_hold_req = 1'b0;
    logic long_hold_done = 1'b0;
    int   hold_left = HOLD_CYCLES;
    int   errors = 0;

    static_linked_list_engine_core #(
        .SLOTS(LIST_SLOTS)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    always #6 clk = ~clk;

    // Applies one operation to the shadow list and records its result.
    function automatic void predict_list_op(sll_pkg::t_in op);
        sll_pkg::t_out res;
        int   pos;
        int   limit;
        int   slot;
        int   pred;
        int   victim;
        int   k;
        res   = '0;
        pos   = op.position;
        limit = (op.mode == sll_pkg::MODE_INSERT) ? list_count + 1 : list_count;
        if (pos < 1 || pos > limit) begin
            res.status = sll_pkg::ST_RANGE;
        end else if (op.mode == sll_pkg::MODE_INSERT &&
                     (list_link[FREE_HEAD] == FREE_HEAD ||
                      list_link[FREE_HEAD] == DATA_HEAD)) begin
            res.status = sll_pkg::ST_FULL;
        end else begin
            pred = DATA_HEAD;
            for (k = 1; k < pos; k++) begin
                pred = list_link[pred];
            end
            if (op.mode == sll_pkg::MODE_INSERT) begin
                slot                 = list_link[FREE_HEAD];
                list_link[FREE_HEAD] = list_link[slot];
                list_link[slot]      = list_link[pred];
                list_link[pred]      = slot[7:0];
                list_value[slot]     = op.value;
                list_count++;
            end else begin
                victim                = list_link[pred];
                list_link[pred]       = list_link[victim];
                res.removed_value     = list_value[victim];
                list_link[victim]     = list_link[FREE_HEAD];
                list_link[FREE_HEAD]  = victim[7:0];
                list_count--;
            end
            res.status = sll_pkg::ST_DONE;
        end
        res.count = list_count[7:0];
        expected_results.push_back(res);
    endfunction

    function automatic void queue_list_op(logic mode, int pos, logic [31:0] value);
        sll_pkg::t_in op;
        op.mode     = mode;
        op.position = pos[7:0];
        op.value    = value;
        pending_ops.push_back(op);
        if (mode == sll_pkg::MODE_INSERT) begin
            if (pos >= 1 && pos <= gen_count + 1 && gen_count < MAX_ELEMENTS) begin
                gen_count++;
            end
        end else if (pos >= 1 && pos <= gen_count) begin
            gen_count--;
        end
    endfunction

    // Mostly well-formed positions; about one in ten is drawn from the whole
    // field so that out-of-range positions keep turning up.
    function automatic void queue_random_op(int insert_pct);
        logic mode;
        int   pos;
        if ($urandom_range(99) < 10) begin
            mode = 1'($urandom_range(1));
            pos  = $urandom_range(255);
        end else begin
            if (gen_count == 0 || $urandom_range(99) < insert_pct) begin
                mode = sll_pkg::MODE_INSERT;
                pos  = $urandom_range(gen_count + 1, 1);
            end else begin
                mode = sll_pkg::MODE_DELETE;
                pos  = $urandom_range(gen_count, 1);
            end
        end
        queue_list_op(mode, pos, $urandom);
    endfunction

    task automatic wait_list_idle();
        while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0) begin
            @(posedge clk);
        end
    endtask

    // Driver: a new transaction is offered only once the previous one has
    // been taken, so a stalled payload never changes.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                predict_list_op(in_data);
            end
            if (!in_valid || !in_stall) begin
                if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_data  <= pending_ops.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall, with one long hold-off on request.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (long_hold_req && !long_hold_done) begin
            out_stall <= 1'b1;
            if (hold_left == 0) begin
                long_hold_done <= 1'b1;
            end else begin
                hold_left <= hold_left - 1;
            end
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        sll_pkg::t_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result transaction: status %0d count %0d",
                       out_data.status, out_data.count);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (out_data.status !== want.status) begin
                    $error("status mismatch: expected %0d, got %0d",
                           want.status, out_data.status);
                    errors++;
                end
                if (out_data.count !== want.count) begin
                    $error("count mismatch: expected %0d, got %0d",
                           want.count, out_data.count);
                    errors++;
                end
                if (out_data.removed_value !== want.removed_value) begin
                    $error("removed_value mismatch: expected %0d, got %0d",
                           want.removed_value, out_data.removed_value);
                    errors++;
                end
            end
        end
    end

    initial begin
        int i;
        for (i = 0; i < LIST_SLOTS; i++) begin
            list_link[i]  = (i + 1 < LIST_SLOTS - 1) ? 8'(i + 1) : 8'd0;
            list_value[i] = '0;
        end
        list_count = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: range errors on an empty and on a filled list, inserts at head,
        // tail and middle with extreme values, then deletes from every place.
        queue_list_op(sll_pkg::MODE_DELETE, 1, 32'h0);
        queue_list_op(sll_pkg::MODE_INSERT, 0, 32'h1234_5678);
        queue_list_op(sll_pkg::MODE_INSERT, 2, 32'h1);
        queue_list_op(sll_pkg::MODE_INSERT, 255, 32'hFFFF_FFFF);
        queue_list_op(sll_pkg::MODE_INSERT, 1, 32'h7FFF_FFFF);
        queue_list_op(sll_pkg::MODE_INSERT, 1, 32'h8000_0000);
        queue_list_op(sll_pkg::MODE_INSERT, 3, 32'h0);
        queue_list_op(sll_pkg::MODE_INSERT, 2, 32'hFFFF_FFFF);
        queue_list_op(sll_pkg::MODE_INSERT, 6, 32'h5555_5555);
        queue_list_op(sll_pkg::MODE_DELETE, 0, 32'hFFFF_FFFF);
        queue_list_op(sll_pkg::MODE_DELETE, 5, 32'h0);
        queue_list_op(sll_pkg::MODE_DELETE, 4, 32'hAAAA_AAAA);
        queue_list_op(sll_pkg::MODE_INSERT, 4, 32'hAAAA_AAAA);
        queue_list_op(sll_pkg::MODE_DELETE, 1, 32'h0);
        queue_list_op(sll_pkg::MODE_DELETE, 2, 32'h0);
        queue_list_op(sll_pkg::MODE_DELETE, 3, 32'h0);
        queue_list_op(sll_pkg::MODE_DELETE, 1, 32'h0);
        queue_list_op(sll_pkg::MODE_DELETE, 1, 32'h0);
        queue_list_op(sll_pkg::MODE_DELETE, 255, 32'h0);
        wait_list_idle();

        // No idling, with a long receiver hold-off so that the engine backs up.
        long_hold_req = 1'b1;
        for (i = 0; i < 60; i++) queue_random_op(50);
        while (!long_hold_done) @(posedge clk);
        wait_list_idle();

        // Sender idles; the list is filled to capacity and then pushed past it.
        send_idle_pct = 62;
        while (gen_count < MAX_ELEMENTS) queue_random_op(95);
        queue_list_op(sll_pkg::MODE_INSERT, 255, $urandom);
        queue_list_op(sll_pkg::MODE_INSERT, 1, $urandom);
        queue_list_op(sll_pkg::MODE_INSERT, 0, $urandom);
        queue_list_op(sll_pkg::MODE_DELETE, 255, $urandom);
        queue_list_op(sll_pkg::MODE_DELETE, MAX_ELEMENTS, $urandom);
        queue_list_op(sll_pkg::MODE_INSERT, MAX_ELEMENTS, $urandom);
        wait_list_idle();

        // Receiver stalls while the list drains.
        send_idle_pct  = 0;
        recv_stall_pct = 62;
        for (i = 0; i < 100; i++) queue_random_op(25);
        wait_list_idle();

        send_idle_pct  = 28;
        recv_stall_pct = 28;
        for (i = 0; i < 80; i++) queue_random_op(50);
        wait_list_idle();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #15_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
